@@ hw/rtl/lkr_pkg.sv @@
`timescale 1ns / 1ps

package lkr_pkg;

   localparam int DEFAULT_FRAME_SLOTS = 16;
   localparam int STAMP_W             = 64;
   localparam int COUNT_W             = 4;
   localparam int DEPTH_W             = 4;
   localparam int FRAME_W             = 4;
   localparam int EVCOUNT_W           = 5;

   localparam logic [DEPTH_W-1:0] HISTORY_DEPTH_RESET = 4'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX           = 4'd15;

   typedef enum logic [1:0] {
      OP_ACCESS    = 2'd0,
      OP_SET_EVICT = 2'd1,
      OP_REMOVE    = 2'd2,
      OP_EVICT     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK            = 2'd0,
      STAT_NOT_TRACKED   = 2'd1,
      STAT_NOT_EVICTABLE = 2'd2,
      STAT_FULL          = 2'd3
   } status_type;

   // One frame record as held in the frame memory.
   typedef struct packed {
      logic               evictable;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } frame_rec_type;

   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctrl_type;

endpackage

@@ hw/rtl/lkr_frame_mem.sv @@
`timescale 1ns / 1ps

module lkr_frame_mem
   import lkr_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_FRAME_SLOTS,
   parameter int ADDR_W = $clog2(DEFAULT_FRAME_SLOTS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  frame_rec_type     wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output frame_rec_type     rd_data
);

   frame_rec_type mem [DEPTH];
   frame_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lkr_victim_scan.sv @@
`timescale 1ns / 1ps

module lkr_victim_scan
   import lkr_pkg::*;
#(
   parameter int IDX_W = $clog2(DEFAULT_FRAME_SLOTS)
) (
   input  logic               clock,
   input  logic               reset,
   input  scan_ctrl_type      ctrl,
   input  logic               entry_live,
   input  frame_rec_type      entry,
   input  logic [IDX_W-1:0]   entry_idx,
   input  logic [DEPTH_W-1:0] history_depth,
   output logic               victim_found,
   output logic [IDX_W-1:0]   victim_idx
);

   logic               fifo_found_ff, fifo_found_in;
   logic [IDX_W-1:0]   fifo_idx_ff, fifo_idx_in;
   logic [STAMP_W-1:0] fifo_stamp_ff, fifo_stamp_in;
   logic               lru_found_ff, lru_found_in;
   logic [IDX_W-1:0]   lru_idx_ff, lru_idx_in;
   logic [STAMP_W-1:0] lru_stamp_ff, lru_stamp_in;
   logic               in_lru;

   assign in_lru = entry.count >= history_depth;

   always_comb begin
      fifo_found_in = fifo_found_ff;
      fifo_idx_in   = fifo_idx_ff;
      fifo_stamp_in = fifo_stamp_ff;
      lru_found_in  = lru_found_ff;
      lru_idx_in    = lru_idx_ff;
      lru_stamp_in  = lru_stamp_ff;
      if (ctrl.clear) begin
         fifo_found_in = 1'b0;
         lru_found_in  = 1'b0;
      end else if (ctrl.sample && entry_live) begin
         // strict compare keeps the lowest index on equal stamps
         if (!in_lru) begin
            if (!fifo_found_ff || entry.stamp < fifo_stamp_ff) begin
               fifo_found_in = 1'b1;
               fifo_idx_in   = entry_idx;
               fifo_stamp_in = entry.stamp;
            end
         end else begin
            if (!lru_found_ff || entry.stamp < lru_stamp_ff) begin
               lru_found_in = 1'b1;
               lru_idx_in   = entry_idx;
               lru_stamp_in = entry.stamp;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_found_ff <= 1'b0;
         lru_found_ff  <= 1'b0;
      end else begin
         fifo_found_ff <= fifo_found_in;
         lru_found_ff  <= lru_found_in;
      end
   end

   always_ff @(posedge clock) begin
      fifo_idx_ff   <= fifo_idx_in;
      fifo_stamp_ff <= fifo_stamp_in;
      lru_idx_ff    <= lru_idx_in;
      lru_stamp_ff  <= lru_stamp_in;
   end

   // FIFO group wins over the LRU group
   assign victim_found = fifo_found_ff || lru_found_ff;
   assign victim_idx   = fifo_found_ff ? fifo_idx_ff : lru_idx_ff;

endmodule

@@ hw/rtl/lru_k_frame_replacer_core.sv @@
`timescale 1ns / 1ps
// Ops answered at once (reject, new-frame insert, evict with none evictable) answer in the
// cycle after accept; access, set-evictable and remove of a tracked frame take one
// read-modify-write of the frame memory. Evict, and access of a new frame into a full
// table, scan the frame memory one record per cycle through its single read port if any is
// evictable. One op is in flight at a time; the next op enters once the result beat is taken.
// Reset (synchronous): no frame tracked, stamp and totals zero, history depth 2.

module lru_k_frame_replacer_core
   import lkr_pkg::*;
#(
   parameter int FRAME_SLOTS = DEFAULT_FRAME_SLOTS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_opcode,
   input  logic [$clog2(FRAME_SLOTS)-1:0]        req_frame_index,
   input  logic                                  req_evictable_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_victim_valid,
   output logic [$clog2(FRAME_SLOTS)-1:0]        rsp_victim_frame,
   output logic [1:0]                            rsp_status,
   output logic [$clog2(FRAME_SLOTS + 1)-1:0]    rsp_evictable_count,
   input  logic                                  csr_write_enable,
   input  logic [DEPTH_W-1:0]                    csr_write_data
);

   localparam int IDX_W = $clog2(FRAME_SLOTS);
   localparam int CNT_W = $clog2(FRAME_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_SLOTS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_SLOTS);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_MODIFY = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   opcode_type             op_ff, op_in;
   logic [IDX_W-1:0]       fi_ff, fi_in;
   logic                   ev_ff, ev_in;
   logic [DEPTH_W-1:0]     k_ff, k_in;
   logic [FRAME_SLOTS-1:0] present_ff, present_in;
   logic [STAMP_W-1:0]     stamp_ff, stamp_in;
   logic [CNT_W-1:0]       tracked_ff, tracked_in;
   logic [CNT_W-1:0]       evtotal_ff, evtotal_in;
   logic [IDX_W-1:0]       scan_addr_ff, scan_addr_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_vvalid_ff, rsp_vvalid_in;
   logic [IDX_W-1:0]       rsp_vframe_ff, rsp_vframe_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                   req_fire;
   logic                   req_in_range;
   logic [IDX_W-1:0]       req_idx;
   opcode_type             req_op;
   logic                   rsp_load;
   logic                   res_vvalid;
   logic [IDX_W-1:0]       res_vidx;
   status_type             res_status;
   logic [COUNT_W-1:0]     new_count;

   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   frame_rec_type          mem_wr_data;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   frame_rec_type          mem_rd_data;

   scan_ctrl_type          scan_ctrl;
   logic                   victim_found;
   logic [IDX_W-1:0]       victim_idx;

   assign req_ready    = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire     = req_valid && req_ready;
   assign req_in_range = 32'(req_frame_index) < FRAME_SLOTS;
   assign req_idx      = req_frame_index;
   assign req_op       = opcode_type'(req_opcode);

   lkr_frame_mem #(
      .DEPTH  (FRAME_SLOTS),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lkr_victim_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (scan_ctrl),
      .entry_live    (present_ff[cmp_idx_ff] && mem_rd_data.evictable),
      .entry         (mem_rd_data),
      .entry_idx     (cmp_idx_ff),
      .history_depth (k_ff),
      .victim_found  (victim_found),
      .victim_idx    (victim_idx)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      fi_in        = fi_ff;
      ev_in        = ev_ff;
      k_in         = csr_write_enable ? csr_write_data : k_ff;
      present_in   = present_ff;
      stamp_in     = stamp_ff;
      tracked_in   = tracked_ff;
      evtotal_in   = evtotal_ff;
      scan_addr_in = scan_addr_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = fi_ff;
      mem_wr_data  = '{evictable: 1'b0, count: COUNT_W'(1), stamp: stamp_ff};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = req_idx;
      scan_ctrl    = '{clear: 1'b0, sample: cmp_valid_ff};
      rsp_load     = 1'b0;
      res_vvalid   = 1'b0;
      res_vidx     = '0;
      res_status   = STAT_OK;
      new_count    = (mem_rd_data.count < COUNT_MAX) ? mem_rd_data.count + 1'b1 : COUNT_MAX;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in = req_op;
               fi_in = req_idx;
               ev_in = req_evictable_value;
               if (req_op == OP_EVICT) begin
                  if (evtotal_ff == '0) begin
                     rsp_load = 1'b1;
                  end else begin
                     state_in       = S_SCAN;
                     scan_addr_in   = '0;
                     scan_ctrl.clear = 1'b1;
                  end
               end else if (!req_in_range) begin
                  rsp_load   = 1'b1;
                  res_status = STAT_NOT_TRACKED;
               end else if (present_ff[req_idx]) begin
                  mem_rd_en = 1'b1;
                  state_in  = S_MODIFY;
               end else if (req_op == OP_ACCESS) begin
                  if (tracked_ff >= FULL_CNT) begin
                     if (evtotal_ff == '0) begin
                        rsp_load   = 1'b1;
                        res_status = STAT_FULL;
                     end else begin
                        state_in        = S_SCAN;
                        scan_addr_in    = '0;
                        scan_ctrl.clear = 1'b1;
                     end
                  end else begin
                     // insert with a fresh stamp
                     mem_wr_en           = 1'b1;
                     mem_wr_addr         = req_idx;
                     present_in[req_idx] = 1'b1;
                     stamp_in            = stamp_ff + 1'b1;
                     tracked_in          = tracked_ff + 1'b1;
                     rsp_load            = 1'b1;
                  end
               end else begin
                  rsp_load   = 1'b1;
                  res_status = STAT_NOT_TRACKED;
               end
            end
         end
         S_MODIFY: begin
            rsp_load    = 1'b1;
            state_in    = S_IDLE;
            mem_wr_data = mem_rd_data;
            case (op_ff)
               OP_ACCESS: begin
                  mem_wr_en         = 1'b1;
                  mem_wr_data.count = new_count;
                  if (new_count >= k_ff) begin
                     mem_wr_data.stamp = stamp_ff;
                     stamp_in          = stamp_ff + 1'b1;
                  end
               end
               OP_SET_EVICT: begin
                  if (mem_rd_data.evictable != ev_ff) begin
                     mem_wr_en             = 1'b1;
                     mem_wr_data.evictable = ev_ff;
                     evtotal_in = ev_ff ? evtotal_ff + 1'b1 : evtotal_ff - 1'b1;
                  end
               end
               default: begin
                  if (mem_rd_data.evictable) begin
                     present_in[fi_ff] = 1'b0;
                     tracked_in        = tracked_ff - 1'b1;
                     evtotal_in        = evtotal_ff - 1'b1;
                  end else begin
                     res_status = STAT_NOT_EVICTABLE;
                  end
               end
            endcase
         end
         S_SCAN: begin
            mem_rd_en    = 1'b1;
            mem_rd_addr  = scan_addr_ff;
            cmp_valid_in = 1'b1;
            cmp_idx_in   = scan_addr_ff;
            if (scan_addr_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
            if (victim_found) begin
               res_vvalid             = 1'b1;
               res_vidx               = victim_idx;
               present_in[victim_idx] = 1'b0;
               tracked_in             = tracked_ff - 1'b1;
               evtotal_in             = evtotal_ff - 1'b1;
               if (op_ff == OP_ACCESS) begin
                  // new frame takes the victim's slot in the count
                  mem_wr_en         = 1'b1;
                  present_in[fi_ff] = 1'b1;
                  stamp_in          = stamp_ff + 1'b1;
                  tracked_in        = tracked_ff;
               end
            end else if (op_ff == OP_ACCESS) begin
               res_status = STAT_FULL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_vvalid_in = rsp_vvalid_ff;
      rsp_vframe_in = rsp_vframe_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_vvalid_in = res_vvalid;
         rsp_vframe_in = res_vidx;
         rsp_status_in = res_status;
         rsp_count_in  = evtotal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= HISTORY_DEPTH_RESET;
         present_ff   <= '0;
         stamp_ff     <= '0;
         tracked_ff   <= '0;
         evtotal_ff   <= '0;
         scan_addr_ff <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         present_ff   <= present_in;
         stamp_ff     <= stamp_in;
         tracked_ff   <= tracked_in;
         evtotal_ff   <= evtotal_in;
         scan_addr_ff <= scan_addr_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      fi_ff         <= fi_in;
      ev_ff         <= ev_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
      rsp_vframe_ff <= rsp_vframe_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_victim_valid    = rsp_vvalid_ff;
   assign rsp_victim_frame    = rsp_vframe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_evictable_count = rsp_count_ff;

   a_evict_le_tracked: assert property (@(posedge clock) disable iff (reset)
      evtotal_ff <= tracked_ff)
      else $error("evictable total exceeds tracked total");

   a_tracked_bound: assert property (@(posedge clock) disable iff (reset)
      tracked_ff <= FULL_CNT)
      else $error("tracked total exceeds frame count");

   a_scan_finds_victim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && evtotal_ff != '0) |-> victim_found)
      else $error("scan missed an evictable frame");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid_ff || state_ff != S_IDLE))
      else $error("accepted beat produced no work");

   a_tracked_present: assert property (@(posedge clock) disable iff (reset)
      tracked_ff == CNT_W'($countones(present_ff)))
      else $error("tracked total out of step with present bits");

endmodule
